// ===== hdl/tql_pkg.sv =====
`default_nettype none

package tql_pkg;

    localparam int X_SIZE   = 512;
    localparam int Y_SIZE   = 1024;
    localparam int X_REF    = 75;
    localparam int X_OFFSET = 100;
    localparam int Y_OFFSET = 600;

    localparam int X_W    = $clog2(X_SIZE);
    localparam int Y_W    = $clog2(Y_SIZE);
    localparam int ADDR_W = X_W + Y_W;

    localparam int PIX_W = 10;
    localparam int IDX_W = PIX_W + 3;

    localparam int Q_W    = 32;
    localparam int TGT_W  = Q_W + 1;
    localparam int DIFF_W = TGT_W + 1;
    localparam int HALF_W = DIFF_W / 2;
    localparam int PP_W   = 16 + HALF_W + 2;
    localparam int SUM_W  = PP_W + HALF_W;
    localparam int STEP_W = SUM_W - 16;
    localparam int RES_W  = STEP_W + 1;

    localparam logic [1:0] CFG_LEARN_RATE    = 2'd0;
    localparam logic [1:0] CFG_LIVE_REWARD   = 2'd1;
    localparam logic [1:0] CFG_DEATH_PENALTY = 2'd2;

    localparam logic [15:0] LEARN_RATE_RST    = 16'd45875;
    localparam logic [15:0] LIVE_REWARD_RST   = 16'd1;
    localparam logic [15:0] DEATH_PENALTY_RST = 16'hff9c;

    typedef logic signed [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CUR,
        ST_PREV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic        [15:0] learn_rate;
        logic signed [15:0] live_reward;
        logic signed [15:0] death_penalty;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic in_ready;
        logic load_in;
        logic rd_prev;
        logic load_cur;
        logic load_prev;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/tql_ctrl.sv =====
`default_nettype none

module tql_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire tql_pkg::status_t status,
    output tql_pkg::cmd_t         cmd
);

    tql_pkg::state_t state_reg;
    tql_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tql_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tql_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = tql_pkg::ST_IDLE;
                end
            end
            tql_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tql_pkg::ST_CUR;
                end
            end
            tql_pkg::ST_CUR:    state_next = tql_pkg::ST_PREV;
            tql_pkg::ST_PREV:   state_next = tql_pkg::ST_MUL_LO;
            tql_pkg::ST_MUL_LO: state_next = tql_pkg::ST_MUL_HI;
            tql_pkg::ST_MUL_HI: state_next = tql_pkg::ST_SUM;
            tql_pkg::ST_SUM:    state_next = tql_pkg::ST_WRITE;
            tql_pkg::ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = tql_pkg::ST_IDLE;
                end
            end
            default:            state_next = tql_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            tql_pkg::ST_CLEAR:  cmd.clear = 1'b1;
            tql_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load_in  = in_valid;
            end
            tql_pkg::ST_CUR:
            begin
                cmd.rd_prev  = 1'b1;
                cmd.load_cur = 1'b1;
            end
            tql_pkg::ST_PREV:   cmd.load_prev = 1'b1;
            tql_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
            tql_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
            tql_pkg::ST_SUM:    cmd.sum = 1'b1;
            tql_pkg::ST_WRITE:  cmd.commit = status.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tql_datapath.sv =====
`default_nettype none

module tql_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tql_pkg::cmd_t    cmd,
    input  wire tql_pkg::cfg_t    cfg,
    output tql_pkg::status_t      status,
    input  wire logic [31:0]      in_data,
    input  wire logic             in_alive,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           out_data,
    output logic [2:0]            out_flags
);

    localparam int ADDR_W = tql_pkg::ADDR_W;
    localparam int X_W    = tql_pkg::X_W;
    localparam int Y_W    = tql_pkg::Y_W;
    localparam int Q_W    = tql_pkg::Q_W;
    localparam int HALF_W = tql_pkg::HALF_W;
    localparam int PIX_W  = tql_pkg::PIX_W;

    logic [2*Q_W-1:0] mem [2**ADDR_W];
    logic [2*Q_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [2*Q_W-1:0] wr_data;

    logic [ADDR_W-1:0] clr_addr_reg;

    logic [X_W-1:0] cx_reg;
    logic [Y_W-1:0] cy_reg;
    logic           alive_reg;
    logic           clamped_reg;
    logic [X_W-1:0] prev_x_reg;
    logic [Y_W-1:0] prev_y_reg;
    logic           prev_action_reg;

    logic [2*Q_W-1:0]                 cur_entry_reg;
    logic [2*Q_W-1:0]                 prev_entry_reg;
    logic signed [tql_pkg::TGT_W-1:0]  target_reg;
    logic signed [tql_pkg::DIFF_W-1:0] d_reg;
    logic signed [tql_pkg::PP_W-1:0]   pp_lo_reg;
    logic signed [tql_pkg::PP_W-1:0]   pp_hi_reg;
    logic signed [tql_pkg::STEP_W-1:0] step_reg;

    logic                 out_valid_reg;
    logic [Q_W-1:0]       out_value_reg;
    logic [2:0]           out_flags_reg;

    // index forming and clamping
    tql_pkg::idx_t  cx_s;
    tql_pkg::idx_t  cy_s;
    logic [X_W-1:0] cx_c;
    logic [Y_W-1:0] cy_c;
    logic           clamp_x;
    logic           clamp_y;

    always_comb
    begin
        cx_s = tql_pkg::idx_t'({3'b0, in_data[PIX_W-1:0]}) - tql_pkg::idx_t'(tql_pkg::X_REF)
             + tql_pkg::idx_t'(tql_pkg::X_OFFSET);
        cy_s = tql_pkg::idx_t'({3'b0, in_data[2*PIX_W-1:PIX_W]})
             - tql_pkg::idx_t'({3'b0, in_data[3*PIX_W-1:2*PIX_W]})
             + tql_pkg::idx_t'(tql_pkg::Y_OFFSET);
        clamp_x = 1'b0;
        clamp_y = 1'b0;
        cx_c    = cx_s[X_W-1:0];
        cy_c    = cy_s[Y_W-1:0];
        if (cx_s < 0)
        begin
            cx_c    = '0;
            clamp_x = 1'b1;
        end
        else if (cx_s > tql_pkg::idx_t'(tql_pkg::X_SIZE - 1))
        begin
            cx_c    = X_W'(tql_pkg::X_SIZE - 1);
            clamp_x = 1'b1;
        end
        if (cy_s < 0)
        begin
            cy_c    = '0;
            clamp_y = 1'b1;
        end
        else if (cy_s > tql_pkg::idx_t'(tql_pkg::Y_SIZE - 1))
        begin
            cy_c    = Y_W'(tql_pkg::Y_SIZE - 1);
            clamp_y = 1'b1;
        end
    end

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] prev_addr;

    assign cur_addr  = {cx_reg, cy_reg};
    assign prev_addr = {prev_x_reg, prev_y_reg};
    assign rd_addr   = cmd.rd_prev ? prev_addr : {cx_c, cy_c};

    // Q table: slot 0 (jump) in the low word, slot 1 (wait) in the high word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = &clr_addr_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // best value at the current state and the blend target
    logic signed [Q_W-1:0] cur_jump;
    logic signed [Q_W-1:0] cur_wait;
    logic signed [Q_W-1:0] best;
    logic signed [15:0]    reward;
    logic signed [Q_W-1:0] prev_val_rd;

    assign cur_jump    = rd_data[Q_W-1:0];
    assign cur_wait    = rd_data[2*Q_W-1:Q_W];
    assign best        = (cur_jump > cur_wait) ? cur_jump : cur_wait;
    assign reward      = alive_reg ? cfg.live_reward : cfg.death_penalty;
    assign prev_val_rd = prev_action_reg ? rd_data[2*Q_W-1:Q_W] : rd_data[Q_W-1:0];

    // alpha * d in two partial products
    logic signed [HALF_W+1:0]       mul_b;
    logic signed [16:0]             mul_a;
    logic signed [tql_pkg::PP_W-1:0] product;

    assign mul_a   = $signed({1'b0, cfg.learn_rate});
    assign mul_b   = cmd.mul_lo ? $signed({2'b0, d_reg[HALF_W-1:0]})
                                : $signed({{2{d_reg[2*HALF_W-1]}},
                                           d_reg[2*HALF_W-1:HALF_W]});
    assign product = tql_pkg::PP_W'(mul_a * mul_b);

    logic signed [tql_pkg::SUM_W-1:0] sum;

    assign sum = $signed({pp_hi_reg, {HALF_W{1'b0}}})
               + tql_pkg::SUM_W'(pp_lo_reg)
               + tql_pkg::SUM_W'(32768);

    // final add, saturation and the entry written back
    logic signed [tql_pkg::RES_W-1:0] res;
    logic signed [Q_W-1:0]            new_val;
    logic [2*Q_W-1:0]                 new_entry;
    logic [2*Q_W-1:0]                 cur_after;
    logic signed [Q_W-1:0]            prev_val;
    logic                             jump;

    assign prev_val = prev_action_reg ? prev_entry_reg[2*Q_W-1:Q_W] : prev_entry_reg[Q_W-1:0];

    always_comb
    begin
        res = tql_pkg::RES_W'(prev_val) + tql_pkg::RES_W'(step_reg);
        if (res > tql_pkg::RES_W'(signed'(32'sh7fffffff)))
        begin
            new_val = 32'sh7fffffff;
        end
        else if (res < tql_pkg::RES_W'(signed'(32'sh80000000)))
        begin
            new_val = 32'sh80000000;
        end
        else
        begin
            new_val = res[Q_W-1:0];
        end
        new_entry = prev_action_reg ? {new_val, prev_entry_reg[Q_W-1:0]}
                                    : {prev_entry_reg[2*Q_W-1:Q_W], new_val};
        cur_after = (cur_addr == prev_addr) ? new_entry : cur_entry_reg;
        jump      = $signed(cur_after[Q_W-1:0]) > $signed(cur_after[2*Q_W-1:Q_W]);
    end

    assign we      = cmd.clear || cmd.commit;
    assign wr_addr = cmd.clear ? clr_addr_reg : prev_addr;
    assign wr_data = cmd.clear ? '0 : new_entry;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cx_reg      <= cx_c;
            cy_reg      <= cy_c;
            alive_reg   <= in_alive;
            clamped_reg <= clamp_x || clamp_y;
        end
        if (cmd.load_cur)
        begin
            cur_entry_reg <= rd_data;
            target_reg    <= tql_pkg::TGT_W'($signed({reward, 16'b0}))
                           + tql_pkg::TGT_W'(best);
        end
        if (cmd.load_prev)
        begin
            prev_entry_reg <= rd_data;
            d_reg          <= tql_pkg::DIFF_W'(target_reg) - tql_pkg::DIFF_W'(prev_val_rd);
        end
        if (cmd.mul_lo)
        begin
            pp_lo_reg <= product;
        end
        if (cmd.mul_hi)
        begin
            pp_hi_reg <= product;
        end
        if (cmd.sum)
        begin
            step_reg <= sum[tql_pkg::SUM_W-1:16];
        end
        if (cmd.commit)
        begin
            out_value_reg <= new_val;
            out_flags_reg <= {clamped_reg, alive_reg, jump && alive_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_action_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit && alive_reg)
            begin
                prev_x_reg      <= cx_reg;
                prev_y_reg      <= cy_reg;
                prev_action_reg <= !jump;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_value_reg;
    assign out_flags = out_flags_reg;

endmodule

`default_nettype wire

// ===== hdl/tabular_q_learning_update.sv =====
`default_nettype none

// channel   dir   handshake                   payload
// s_*       in    s_tvalid / s_tready         s_tdata: target_x, target_y, bird_y; s_tuser: alive
// m_*       out   m_tvalid / m_tready         m_tdata: new_value; m_tuser: jump, acted, clamped
// cfg_*     in    cfg_valid / cfg_ready       cfg_index, cfg_data (always ready)
//
// An item passes from its request to the result register in these steps: two table reads on
// the single read port, two partial products of the 16 x 34 bit blend multiply, sum, write
// back. A new request is taken only after the previous item has been written back.
// After reset a clearing pass writes all 524288 table entries to zero, with s_tready low.
// A result waits in the output register; the write-back holds while it is not taken.

module tabular_q_learning_update (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // target_x[9:0], target_y[19:10], bird_y[29:20], zero
    input  wire logic        s_tuser,   // alive
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // new_value[31:0]
    output logic [2:0]       m_tuser,   // jump, acted, clamped
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    tql_pkg::cmd_t    cmd;
    tql_pkg::status_t status;
    tql_pkg::cfg_t    cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate    <= tql_pkg::LEARN_RATE_RST;
            cfg_reg.live_reward   <= tql_pkg::LIVE_REWARD_RST;
            cfg_reg.death_penalty <= tql_pkg::DEATH_PENALTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tql_pkg::CFG_LEARN_RATE:    cfg_reg.learn_rate    <= cfg_data;
                tql_pkg::CFG_LIVE_REWARD:   cfg_reg.live_reward   <= cfg_data;
                tql_pkg::CFG_DEATH_PENALTY: cfg_reg.death_penalty <= cfg_data;
                default:                    ;
            endcase
        end
    end

    tql_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tql_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .status    (status),
        .in_data   (s_tdata),
        .in_alive  (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flags (m_tuser)
    );

    assign s_tready = cmd.in_ready;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while pending");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while an item is in flight");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !s_tready)
        else $error("request taken during table clear");

endmodule

`default_nettype wire

// ===== test/tb_tabular_q_learning_update.sv =====
`default_nettype none

module tb_tabular_q_learning_update;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int HOT_N = 6;
    localparam int PHASES = 7;
    localparam int PHASE_FRAMES = 270;
    localparam longint Q_MAX = 64'sh7fff_ffff;
    localparam longint Q_MIN = -Q_MAX - 1;

    typedef struct packed {
        logic [9:0] target_x;
        logic [9:0] target_y;
        logic [9:0] bird_y;
        logic       alive;
    } frame_t;

    typedef struct packed {
        logic        jump;
        logic        acted;
        logic        clamped;
        logic [31:0] new_value;
    } update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // target_x[9:0], target_y[19:10], bird_y[29:20], zero
    logic        s_tuser = 1'b0;    // alive
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // new_value[31:0]
    logic [2:0]  m_tuser;           // jump, acted, clamped
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tql_pkg::CFG_LEARN_RATE;
    logic [15:0] cfg_data = '0;

    frame_t      frame_queue[$];
    update_t     expected_updates[$];
    frame_t      frame_on_bus = '0;
    int unsigned drive_cnt = 0;
    int unsigned accept_cnt = 0;
    int unsigned result_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned dead_cnt = 0;
    int unsigned clamp_cnt = 0;
    int unsigned sat_cnt = 0;
    int unsigned setting_cnt = 1;

    // predictor state
    int q_values[int];
    int rate_m = int'(tql_pkg::LEARN_RATE_RST);
    int live_m = int'($signed(tql_pkg::LIVE_REWARD_RST));
    int death_m = int'($signed(tql_pkg::DEATH_PENALTY_RST));
    int prev_x_m = 0;
    int prev_y_m = 0;
    int prev_act_m = 0;

    logic quiet;
    assign quiet = (accept_cnt >= 700) && (accept_cnt < 1000);

    tabular_q_learning_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int q_read(input int key);
        return q_values.exists(key) ? q_values[key] : 0;
    endfunction

    // slot 0 holds the jump value, slot 1 the wait value
    function automatic void predict_update(input frame_t f);
        int     cx;
        int     cy;
        int     cur;
        int     prv;
        int     best;
        int     old_q;
        int     reward;
        longint target;
        longint sum;
        logic   clip;
        logic   jmp;
        clip = 1'b0;
        jmp = 1'b0;
        cx = int'(f.target_x) - tql_pkg::X_REF + tql_pkg::X_OFFSET;
        cy = int'(f.target_y) - int'(f.bird_y) + tql_pkg::Y_OFFSET;
        if (cx < 0)
        begin
            cx = 0;
            clip = 1'b1;
        end
        if (cx > tql_pkg::X_SIZE - 1)
        begin
            cx = tql_pkg::X_SIZE - 1;
            clip = 1'b1;
        end
        if (cy < 0)
        begin
            cy = 0;
            clip = 1'b1;
        end
        if (cy > tql_pkg::Y_SIZE - 1)
        begin
            cy = tql_pkg::Y_SIZE - 1;
            clip = 1'b1;
        end
        cur = cx * tql_pkg::Y_SIZE + cy;
        best = (q_read(cur * 2) > q_read(cur * 2 + 1)) ? q_read(cur * 2) : q_read(cur * 2 + 1);
        prv = ((prev_x_m % tql_pkg::X_SIZE) * tql_pkg::Y_SIZE
              + (prev_y_m % tql_pkg::Y_SIZE)) * 2 + prev_act_m;
        old_q = q_read(prv);
        reward = f.alive ? live_m : death_m;
        target = longint'(reward) * 65536 + longint'(best);
        sum = longint'(old_q)
            + ((longint'(rate_m) * (target - longint'(old_q)) + 64'sd32768) >>> 16);
        if (sum > Q_MAX)
        begin
            sum = Q_MAX;
            sat_cnt++;
        end
        else if (sum < Q_MIN)
        begin
            sum = Q_MIN;
            sat_cnt++;
        end
        q_values[prv] = int'(sum);
        if (f.alive)
        begin
            jmp = q_read(cur * 2) > q_read(cur * 2 + 1);
            prev_x_m = cx;
            prev_y_m = cy;
            prev_act_m = jmp ? 0 : 1;
        end
        else
            dead_cnt++;
        if (clip)
            clamp_cnt++;
        expected_updates.push_back('{jump: jmp, acted: f.alive, clamped: clip,
                                     new_value: sum[31:0]});
    endfunction

    function automatic void add_frame(input int tx, input int ty, input int by, input bit alv);
        frame_t f;
        f.target_x = tx[9:0];
        f.target_y = ty[9:0];
        f.bird_y = by[9:0];
        f.alive = alv;
        frame_queue.push_back(f);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (accept_cnt == drive_cnt)
            begin
                if (frame_queue.size() != 0 && (quiet || $urandom_range(99) >= 14))
                begin
                    frame_on_bus = frame_queue.pop_front();
                    drive_cnt++;
                    s_tdata <= {2'b00, frame_on_bus.bird_y, frame_on_bus.target_y,
                                frame_on_bus.target_x};
                    s_tuser <= frame_on_bus.alive;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    // result check, then request capture
    always @(posedge clk)
    begin
        update_t got;
        update_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{jump: m_tuser[0], acted: m_tuser[1], clamped: m_tuser[2],
                        new_value: m_tdata};
                result_cnt++;
                if (expected_updates.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result %0d with nothing pending: %0b %0b %0b %0d",
                                 result_cnt, got.jump, got.acted, got.clamped,
                                 $signed(got.new_value));
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (got.jump !== want.jump || got.acted !== want.acted ||
                        got.clamped !== want.clamped || got.new_value !== want.new_value)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("result %0d: expected %0b %0b %0b %0d, got %0b %0b %0b %0d",
                                     result_cnt, want.jump, want.acted, want.clamped,
                                     $signed(want.new_value), got.jump, got.acted, got.clamped,
                                     $signed(got.new_value));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                accept_cnt++;
                predict_update(frame_on_bus);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tql_pkg::CFG_LEARN_RATE:    rate_m = int'(val);
            tql_pkg::CFG_LIVE_REWARD:   live_m = int'($signed(val));
            tql_pkg::CFG_DEATH_PENALTY: death_m = int'($signed(val));
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] rate, input logic [15:0] live,
                             input logic [15:0] death);
        write_reg(tql_pkg::CFG_LEARN_RATE, rate);
        write_reg(tql_pkg::CFG_LIVE_REWARD, live);
        write_reg(tql_pkg::CFG_DEATH_PENALTY, death);
        setting_cnt++;
    endtask

    // wait for the block to drain and every result to be checked, then idle before going on
    task automatic settle();
        while (frame_queue.size() != 0 || accept_cnt != drive_cnt ||
               expected_updates.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int k;
        int h;
        int hot_tx[HOT_N];
        int hot_ty[HOT_N];
        int hot_by[HOT_N];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: index edges, and clamping at both ends of y and at the high end of x
        add_frame(0, 0, 0, 1'b1);
        add_frame(0, 0, 0, 1'b1);
        add_frame(1023, 1023, 0, 1'b1);
        add_frame(486, 0, 1023, 1'b1);
        add_frame(487, 423, 0, 1'b1);
        add_frame(100, 424, 0, 1'b1);
        add_frame(100, 0, 600, 1'b1);
        add_frame(100, 0, 601, 1'b0);
        add_frame(200, 300, 300, 1'b0);
        add_frame(200, 300, 300, 1'b1);
        settle();

        // full rate, top reward: drive one entry into positive saturation
        write_all(16'hffff, 16'h7fff, 16'h8000);
        write_reg(CFG_UNUSED, 16'h5a5a);
        for (k = 0; k < 6; k++)
            add_frame(300, 500, 400, 1'b1);
        add_frame(300, 500, 400, 1'b0);
        settle();

        // most negative reward: both slots of one state toward negative saturation
        write_reg(tql_pkg::CFG_LIVE_REWARD, 16'h8000);
        for (k = 0; k < 7; k++)
            add_frame(50, 100, 700, 1'b1);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_all(16'h0000, 16'h7fff, 16'h8000);
                1: write_all(16'hffff, 16'($urandom), 16'($urandom));
                2:
                begin
                    write_all(16'($urandom), 16'($urandom), 16'($urandom));
                    write_reg(CFG_UNUSED, 16'($urandom));
                end
                3: write_all(tql_pkg::LEARN_RATE_RST, tql_pkg::LIVE_REWARD_RST,
                             tql_pkg::DEATH_PENALTY_RST);
                4: write_all(16'h0001, 16'h8000, 16'h7fff);
                default: write_all(16'($urandom), 16'($urandom_range(64)),
                                   16'(-$urandom_range(1000)));
            endcase
            for (h = 0; h < HOT_N; h++)
            begin
                hot_tx[h] = $urandom_range(511);
                hot_ty[h] = $urandom_range(1023);
                hot_by[h] = $urandom_range(1023);
            end
            for (k = 0; k < PHASE_FRAMES; k++)
            begin
                h = $urandom_range(HOT_N - 1);
                if ($urandom_range(99) < 65)
                    add_frame(hot_tx[h], hot_ty[h], hot_by[h], $urandom_range(99) >= 12);
                else
                    add_frame($urandom, $urandom, $urandom, 1'($urandom_range(1)));
            end
            settle();
        end

        $display("Covered %0d frames under %0d register settings, %0d dead, %0d clamped.",
                 accept_cnt, setting_cnt, dead_cnt, clamp_cnt);
        $display("Checked %0d results, %0d of them saturated.", result_cnt, sat_cnt);
        fail_cnt += expected_updates.size();
        if (fail_cnt == 0)
            $display("tabular_q_learning_update: match");
        else
            $display("tabular_q_learning_update: mismatch");
        $finish;
    end

    // clearing pass plus all frames, with margin
    initial
    begin
        #30000000;
        $display("tabular_q_learning_update: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
